@@ rtl/multichannel_pwm_timer_assert.svh @@
// Assertion macros for the checker file of the PWM timer.
`ifndef MULTICHANNEL_PWM_TIMER_ASSERT_SVH
`define MULTICHANNEL_PWM_TIMER_ASSERT_SVH

// Check a property on the rising clock edge, held off during reset.
`define MPT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define MPT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/mpt_pkg.sv @@
// Shared constants and types of the multichannel PWM timer.
package mpt_pkg;

    localparam int CountBits   = 16;
    localparam int DutyBits    = 17;
    localparam int PinBits     = 4;
    localparam int ChanBits    = 2;
    localparam int RegIdxBits  = 3;
    localparam int AddrBits    = 5;
    localparam int DataBits    = 32;
    localparam int InDataBits  = 24;
    localparam int InUserBits  = 3;
    localparam int OutDataBits = 24;

    typedef enum logic [1:0] {
        ALIGN_LEFT   = 2'd0,
        ALIGN_RIGHT  = 2'd1,
        ALIGN_CENTER = 2'd2,
        ALIGN_SPARE  = 2'd3
    } align_t;

    typedef enum logic [RegIdxBits-1:0] {
        REG_PRESCALE = 3'd0,
        REG_PERIOD   = 3'd1,
        REG_ALIGN    = 3'd2,
        REG_RUN      = 3'd3,
        REG_CHAN_EN  = 3'd4
    } reg_idx_t;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [CountBits-1:0] PeriodReset = 16'hFFFF;

endpackage

@@ rtl/multichannel_pwm_timer.sv @@
// Multichannel PWM timer: tick and duty-write beats in, pin levels and counter state out.
//
//  channel   direction  beat contents
//  s_        in         tuser {channel, op}, tdata duty
//  m_        out        tdata {count_value, pin_levels}, tuser counting_down, tlast period_end
//  apb       in/out     prescale_limit, period_top, align_mode, run_enable, channel_enable
//
// One beat per cycle while the m_ slot is empty or m_tready takes it; m_tvalid rises in the
// cycle after an s_ accept, and the counter, prescaler and duty registers update on that accept.
// Reset clears config to defaults, counters and duties to zero; no clearing pass.
// A stalled m_ side holds its beat; s_tready stays high while m_tready takes it.
module multichannel_pwm_timer
    import mpt_pkg::*;
#(
    parameter int CHANNELS = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // APB configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [AddrBits-1:0]     paddr,
    input  logic [DataBits-1:0]     pwdata,
    output logic [DataBits-1:0]     prdata,
    output logic                    pready,
    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [InDataBits-1:0]   s_tdata,   // [16:0] duty, rest zero
    input  logic [InUserBits-1:0]   s_tuser,   // [0] op, [2:1] channel
    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OutDataBits-1:0]  m_tdata,   // [3:0] pin_levels, [19:4] count_value, rest zero
    output logic                    m_tuser,   // [0] counting_down
    output logic                    m_tlast    // period_end
);

    logic [CountBits-1:0] prescale_limit_reg;
    logic [CountBits-1:0] period_top_reg;
    align_t               align_mode_reg;
    logic                 run_enable_reg;
    logic [PinBits-1:0]   channel_enable_reg;

    logic [CountBits-1:0] prescale_count_reg, prescale_count_next;
    logic [CountBits-1:0] main_count_reg, main_count_next;
    logic                 down_flag_reg, down_flag_next;
    logic [DutyBits-1:0]  duty_reg  [CHANNELS];
    logic [DutyBits-1:0]  duty_next [CHANNELS];

    logic                 m_valid_reg;
    logic [PinBits-1:0]   pins_reg, pins_next;
    logic [CountBits-1:0] count_out_reg;
    logic                 down_out_reg, down_out_next;
    logic                 wrap_reg, wrap_next;

    logic                 cfg_wr;
    reg_idx_t             cfg_idx;
    logic                 accept;
    logic                 in_op;
    logic [ChanBits-1:0]  in_chan;
    logic [DutyBits-1:0]  in_duty;
    logic [DutyBits-1:0]  duty_limit;
    logic [DutyBits-1:0]  duty_clamped;
    logic                 step;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = reg_idx_t'(paddr[AddrBits-1:2]);
    assign s_tready = ~m_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign in_op    = s_tuser[0];
    assign in_chan  = s_tuser[2:1];
    assign in_duty  = s_tdata[DutyBits-1:0];

    assign duty_limit   = {1'b0, period_top_reg} + DutyBits'(1);
    assign duty_clamped = (in_duty > duty_limit) ? duty_limit : in_duty;

    always_comb begin
        case (cfg_idx)
            REG_PRESCALE: prdata = DataBits'(prescale_limit_reg);
            REG_PERIOD:   prdata = DataBits'(period_top_reg);
            REG_ALIGN:    prdata = DataBits'(align_mode_reg);
            REG_RUN:      prdata = DataBits'(run_enable_reg);
            REG_CHAN_EN:  prdata = DataBits'(channel_enable_reg);
            default:      prdata = '0;
        endcase
    end

    // Prescaler and main counter
    always_comb begin
        prescale_count_next = prescale_count_reg;
        main_count_next     = main_count_reg;
        down_flag_next      = down_flag_reg;
        wrap_next           = 1'b0;
        step                = 1'b0;
        if (in_op == OP_TICK && run_enable_reg) begin
            if (prescale_count_reg >= prescale_limit_reg) begin
                prescale_count_next = '0;
                step                = 1'b1;
            end else begin
                prescale_count_next = prescale_count_reg + CountBits'(1);
            end
        end
        if (step) begin
            if (align_mode_reg != ALIGN_CENTER) begin
                down_flag_next = 1'b0;
                if (main_count_reg >= period_top_reg) begin
                    main_count_next = '0;
                    wrap_next       = 1'b1;
                end else begin
                    main_count_next = main_count_reg + CountBits'(1);
                end
            end else if (period_top_reg == '0) begin
                main_count_next = '0;
                down_flag_next  = 1'b0;
                wrap_next       = 1'b1;
            end else if (down_flag_reg && main_count_reg != '0) begin
                main_count_next = main_count_reg - CountBits'(1);
                if (main_count_reg == CountBits'(1)) begin
                    down_flag_next = 1'b0;
                    wrap_next      = 1'b1;
                end
            end else if (main_count_reg < period_top_reg) begin
                main_count_next = main_count_reg + CountBits'(1);
                down_flag_next  = (main_count_next == period_top_reg);
            end else begin
                main_count_next = main_count_reg - CountBits'(1);
                down_flag_next  = 1'b1;
            end
        end
        down_out_next = (align_mode_reg == ALIGN_CENTER) & down_flag_next;
    end

    // Duty registers and channel compares
    for (genvar c = 0; c < CHANNELS; c++) begin : g_duty
        always_comb begin
            duty_next[c] = duty_reg[c];
            if (in_op == OP_WRITE && {30'd0, in_chan} == c) begin
                duty_next[c] = duty_clamped;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                duty_reg[c] <= '0;
            end else if (accept) begin
                duty_reg[c] <= duty_next[c];
            end
        end
    end

    for (genvar b = 0; b < PinBits; b++) begin : g_pin
        if (b < CHANNELS) begin : g_live
            logic [DutyBits:0] right_sum;
            logic              hit;
            assign right_sum = {2'b00, main_count_next} + {1'b0, duty_next[b]};
            assign hit = (align_mode_reg == ALIGN_RIGHT)
                       ? (right_sum >= {1'b0, duty_limit})
                       : ({1'b0, main_count_next} < duty_next[b]);
            assign pins_next[b] = hit & channel_enable_reg[b];
        end else begin : g_idle
            assign pins_next[b] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_limit_reg <= '0;
            period_top_reg     <= PeriodReset;
            align_mode_reg     <= ALIGN_LEFT;
            run_enable_reg     <= 1'b0;
            channel_enable_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PRESCALE: prescale_limit_reg <= pwdata[CountBits-1:0];
                REG_PERIOD:   period_top_reg     <= pwdata[CountBits-1:0];
                REG_ALIGN:    align_mode_reg     <= align_t'(pwdata[1:0]);
                REG_RUN:      run_enable_reg     <= pwdata[0];
                REG_CHAN_EN:  channel_enable_reg <= pwdata[PinBits-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_count_reg <= '0;
            main_count_reg     <= '0;
            down_flag_reg      <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            if (accept) begin
                prescale_count_reg <= prescale_count_next;
                main_count_reg     <= main_count_next;
                down_flag_reg      <= down_flag_next;
                m_valid_reg        <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pins_reg      <= pins_next;
            count_out_reg <= main_count_next;
            down_out_reg  <= down_out_next;
            wrap_reg      <= wrap_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OutDataBits-PinBits-CountBits)'(0), count_out_reg, pins_reg};
    assign m_tuser  = down_out_reg;
    assign m_tlast  = wrap_reg;

endmodule

@@ rtl/mpt_checker.sv @@
// Port-level checker for the multichannel PWM timer, bound to the top level.
`include "multichannel_pwm_timer_assert.svh"

module mpt_checker
    import mpt_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [OutDataBits-1:0] m_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic                   m_tlast
);

    `MPT_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")

    `MPT_ASSERT(a_ready_rule, s_tready == (!m_tvalid || m_tready), "input ready not tied to output slot")

    `MPT_ASSERT(a_accept_gives_beat, s_tvalid && s_tready |=> m_tvalid, "accepted beat gave no result")

    `MPT_ASSERT(a_wrap_at_zero, m_tvalid && m_tlast |-> m_tdata[19:4] == '0, "period end with counter not zero")

    `MPT_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled beat changed")

endmodule

bind multichannel_pwm_timer mpt_checker u_mpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast)
);
